// ===== src/tepq_pkg.sv =====
// Shared types and codes for the timestamp event priority queue.
package tepq_pkg;

   localparam int ACTION_W = 2;
   localparam int TIME_W   = 64;
   localparam int SERIAL_W = 32;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 5;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_PEEK   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [TIME_W-1:0]   event_time;
      logic [SERIAL_W-1:0] event_serial;
      logic [HANDLE_W-1:0] event_handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TIME_W-1:0]   out_time;
      logic [SERIAL_W-1:0] out_serial;
      logic [HANDLE_W-1:0] out_handle;
      logic                is_empty;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [TIME_W-1:0]   slot_time;
      logic [SERIAL_W-1:0] slot_serial;
      logic [HANDLE_W-1:0] slot_handle;
   } slot_type;

   typedef struct packed {
      logic    valid;
      rsp_type word;
   } result_type;

endpackage

// ===== src/tepq_store.sv =====
// Slot memory with one write port and one registered read port.
module tepq_store import tepq_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output slot_type      rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  slot_type      wr_data
);

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tepq_ctrl.sv =====
// Sequencer that scans the slot memory with one key equality comparator and one key order comparator.
module tepq_ctrl import tepq_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int CW    = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   input  logic          out_free,
   output logic [AW-1:0] rd_addr,
   input  slot_type      rd_data,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output slot_type      wr_data,
   output result_type    result
);

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [AW:0]   issue_ff, issue_in;
   logic          dv_ff, dv_in;
   logic [AW-1:0] didx_ff, didx_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   slot_type      hit_slot_ff, hit_slot_in;
   logic          dup_ff, dup_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic          key_eq;
   logic          earlier;
   logic          wr_req;
   logic [CW-1:0] count_next;

   assign key_eq = rd_data.valid && (rd_data.slot_time == req_ff.event_time) &&
                   (rd_data.slot_serial == req_ff.event_serial);
   assign earlier = rd_data.valid && (!hit_ff ||
                    ({rd_data.slot_time, rd_data.slot_serial} <
                     {hit_slot_ff.slot_time, hit_slot_ff.slot_serial}));

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      issue_in    = issue_ff;
      dv_in       = dv_ff;
      didx_in     = didx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_slot_in = hit_slot_ff;
      dup_in      = dup_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      count_in    = count_ff;
      clr_in      = clr_ff;
      req_ready   = 1'b0;
      rd_addr     = '0;
      wr_req      = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      count_next  = count_ff;
      result      = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               issue_in = '0;
               dv_in    = 1'b0;
               hit_in   = 1'b0;
               dup_in   = 1'b0;
               free_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            dv_in = 1'b0;
            if (issue_ff != (AW+1)'(DEPTH)) begin
               rd_addr  = issue_ff[AW-1:0];
               dv_in    = 1'b1;
               didx_in  = issue_ff[AW-1:0];
               issue_in = issue_ff + 1'b1;
            end
            if (dv_ff) begin
               case (req_ff.action)
                  ACT_INSERT: begin
                     if (key_eq) begin
                        dup_in = 1'b1;
                     end
                     if (!rd_data.valid && !free_ff) begin
                        free_in     = 1'b1;
                        free_idx_in = didx_ff;
                     end
                  end
                  ACT_REMOVE: begin
                     if (key_eq && !hit_ff) begin
                        hit_in      = 1'b1;
                        hit_idx_in  = didx_ff;
                        hit_slot_in = rd_data;
                     end
                  end
                  default: begin
                     if (earlier) begin
                        hit_in      = 1'b1;
                        hit_idx_in  = didx_ff;
                        hit_slot_in = rd_data;
                     end
                  end
               endcase
               if (didx_ff == AW'(DEPTH - 1)) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            result.word.status = ST_OK;
            case (req_ff.action)
               ACT_INSERT: begin
                  if (dup_ff) begin
                     result.word.status = ST_DUPLICATE;
                  end else if (!free_ff) begin
                     result.word.status = ST_FULL;
                  end else begin
                     result.word.out_time   = req_ff.event_time;
                     result.word.out_serial = req_ff.event_serial;
                     result.word.out_handle = req_ff.event_handle;
                     wr_req                 = 1'b1;
                     wr_addr                = free_idx_ff;
                     wr_data.valid          = 1'b1;
                     wr_data.slot_time      = req_ff.event_time;
                     wr_data.slot_serial    = req_ff.event_serial;
                     wr_data.slot_handle    = req_ff.event_handle;
                     count_next             = count_ff + 1'b1;
                  end
               end
               default: begin
                  if (!hit_ff) begin
                     result.word.status = (req_ff.action == ACT_REMOVE) ?
                                          ST_NOT_FOUND : ST_EMPTY;
                  end else begin
                     result.word.out_time   = hit_slot_ff.slot_time;
                     result.word.out_serial = hit_slot_ff.slot_serial;
                     result.word.out_handle = hit_slot_ff.slot_handle;
                     if (req_ff.action != ACT_PEEK) begin
                        wr_req        = 1'b1;
                        wr_addr       = hit_idx_ff;
                        wr_data       = hit_slot_ff;
                        wr_data.valid = 1'b0;
                        count_next    = count_ff - 1'b1;
                     end
                  end
               end
            endcase
            result.word.is_empty  = (count_next == '0);
            result.word.occupancy = OCC_W'(count_next);
            if (out_free) begin
               result.valid = 1'b1;
               wr_en        = wr_req;
               count_in     = count_next;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= '0;
         clr_ff   <= '0;
         dv_ff    <= 1'b0;
         hit_ff   <= 1'b0;
         dup_ff   <= 1'b0;
         free_ff  <= 1'b0;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
         dv_ff    <= dv_in;
         hit_ff   <= hit_in;
         dup_ff   <= dup_in;
         free_ff  <= free_in;
         issue_ff <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      didx_ff     <= didx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_slot_ff <= hit_slot_in;
      free_idx_ff <= free_idx_in;
   end

endmodule

// ===== src/timestamp_event_priority_queue.sv =====
// Top level of the timestamp event priority queue with its result word register.
// A result word is registered after its request word is compared with all slots and the register is free.
// A request is accepted only while the sequencer is idle, so at most one word is in work,
// and a new request word is taken only after the result of the last one is registered.
// The time per word is set by the scan of the slot memory, one slot per cycle.
// After reset every slot of the slot memory is cleared, one after another, before a request is taken.
module timestamp_event_priority_queue import tepq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic          out_free;
   logic [AW-1:0] rd_addr;
   slot_type      rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   slot_type      wr_data;
   result_type    result;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_ready;

   tepq_ctrl #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .result    (result)
   );

   tepq_store #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.word;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in work");

   a_failed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |->
      (rsp_data.out_time == '0) && (rsp_data.out_serial == '0) &&
      (rsp_data.out_handle == '0))
      else $error("failed result word carries a nonzero entry");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> out_free)
      else $error("result word written over a pending one");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !result.valid |=> !rsp_valid)
      else $error("result word repeated after it was taken");
`endif

endmodule
